FILE: rtl/core/bmcl_pkg.sv
`timescale 1ns / 1ps
package bmcl_pkg;

    localparam int BMCL_MAX_WIDTH  = 128;
    localparam int BMCL_MAX_HEIGHT = 128;

    // Configuration register indexes.
    localparam logic CFG_MAP_WIDTH  = 1'b0;
    localparam logic CFG_MAP_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_RUN  = 2'd1,
        CMD_READ = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [1:0] command;
        logic [6:0] col_x;
        logic [6:0] row_y;
        logic       pixel_on;
    } t_in_word;

    typedef struct packed {
        logic        foreground;
        logic [13:0] root_index;
        logic [13:0] group_number;
        logic [14:0] group_count;
    } t_out_word;

    typedef struct packed {
        logic start;
        logic cfg_wr;
        logic take;
    } t_core_ctl;

    typedef struct packed {
        logic busy;
        logic res_valid;
    } t_core_sts;

    typedef enum logic [4:0] {
        ST_IDLE, ST_INIT,
        ST_SC_RD, ST_SC_CUR, ST_SC_RGT, ST_SC_DWN, ST_FA_CHK, ST_FB_CHK,
        ST_CP_RD, ST_CP_CUR, ST_CP_CHK,
        ST_GR_RD, ST_GR_CUR, ST_GR_PAR, ST_GR_SEEN, ST_FIN,
        ST_RD_PIX, ST_RD_PAR, ST_RD_GRP, ST_DONE
    } t_state;

endpackage

FILE: rtl/core/bmcl_core.sv
`timescale 1ns / 1ps
module bmcl_core
    import bmcl_pkg::*;
#(
    parameter int MAX_WIDTH  = BMCL_MAX_WIDTH,
    parameter int MAX_HEIGHT = BMCL_MAX_HEIGHT,
    localparam int DW_W  = $clog2(MAX_WIDTH + 1),
    localparam int DH_W  = $clog2(MAX_HEIGHT + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_core_ctl        i_ctl,
    input  t_in_word         i_word,
    input  logic [DW_W-1:0]  i_w,
    input  logic [DH_W-1:0]  i_h,
    output t_core_sts        o_sts,
    output t_out_word        o_res
);

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int IDX_W = $clog2(CELLS);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int LAB_W = 2 * IDX_W + 1;

    // Label entries are indexed by linear index y*w+x and hold
    // {seen, group, parent}. Pixels are indexed by storage address.
    logic             r_pix_mem [CELLS];
    logic [LAB_W-1:0] r_lab_mem [CELLS];
    logic             r_pix_q;
    logic [LAB_W-1:0] r_lab_q;

    logic             pix_we, pix_wd;
    logic [IDX_W-1:0] pix_wa, pix_ra;
    logic             lab_we;
    logic [IDX_W-1:0] lab_wa, lab_ra;
    logic [LAB_W-1:0] lab_wd;

    t_state r_state, n_state;
    logic [XW-1:0]    r_x, n_x;
    logic [YW-1:0]    r_y, n_y;
    logic [IDX_W-1:0] r_lin, n_lin, r_addr, n_addr;
    logic [IDX_W-1:0] r_cur, n_cur, r_ra, n_ra, r_jb, n_jb;
    logic             r_dir, n_dir;
    logic [IDX_W:0]   r_n, n_n, r_count, n_count, r_groups, n_groups;
    logic             r_valid, n_valid;
    logic [6:0]       r_rx, n_rx, r_ry, n_ry;
    t_out_word        r_res, n_res;

    logic [IDX_W-1:0] lab_par, lab_grp, in_addr, rd_lin;
    logic             lab_seen, last_x, last_y, adv_end, rd_ok, in_store;
    logic [XW-1:0]    adv_x;
    logic [YW-1:0]    adv_y;
    logic [IDX_W-1:0] adv_lin, adv_addr;
    t_cmd             cmd;

    assign cmd      = t_cmd'(i_word.command);
    assign lab_par  = r_lab_q[IDX_W-1:0];
    assign lab_grp  = r_lab_q[2*IDX_W-1:IDX_W];
    assign lab_seen = r_lab_q[2*IDX_W];
    assign last_x   = (DW_W'(r_x) + DW_W'(1)) >= i_w;
    assign last_y   = (DH_W'(r_y) + DH_W'(1)) >= i_h;
    assign adv_end  = last_x && last_y;
    assign in_addr  = IDX_W'(32'(i_word.row_y) * MAX_WIDTH + 32'(i_word.col_x));
    assign in_store = (32'(i_word.col_x) < MAX_WIDTH) && (32'(i_word.row_y) < MAX_HEIGHT);
    assign rd_lin   = IDX_W'(IDX_W'(r_ry) * IDX_W'(i_w) + IDX_W'(r_rx));
    assign rd_ok    = r_valid && r_pix_q && (32'(r_rx) < 32'(i_w)) && (32'(r_ry) < 32'(i_h));

    // Next position of the column-major walk; back to the origin at the end.
    always_comb begin
        adv_x    = r_x;
        adv_y    = r_y + YW'(1);
        adv_lin  = r_lin + IDX_W'(i_w);
        adv_addr = r_addr + IDX_W'(MAX_WIDTH);
        if (adv_end) begin
            adv_x    = '0;
            adv_y    = '0;
            adv_lin  = '0;
            adv_addr = '0;
        end else if (last_y) begin
            adv_x    = r_x + XW'(1);
            adv_y    = '0;
            adv_lin  = IDX_W'(r_x) + IDX_W'(1);
            adv_addr = IDX_W'(r_x) + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_we) begin
            r_pix_mem[pix_wa] <= pix_wd;
        end
        r_pix_q <= r_pix_mem[pix_ra];
    end

    always_ff @(posedge i_clk) begin
        if (lab_we) begin
            r_lab_mem[lab_wa] <= lab_wd;
        end
        r_lab_q <= r_lab_mem[lab_ra];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_ctl.start) begin
                    priority case (cmd)
                        CMD_RUN:  n_state = ST_INIT;
                        CMD_READ: n_state = ST_RD_PIX;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_INIT:   n_state = (r_lin == IDX_W'(r_n - 1'b1)) ? ST_SC_RD : ST_INIT;
            ST_SC_RD:  n_state = ST_SC_CUR;
            ST_SC_CUR: begin
                if (r_pix_q && !last_x) begin
                    n_state = ST_SC_RGT;
                end else if (r_pix_q && !last_y) begin
                    n_state = ST_SC_DWN;
                end else begin
                    n_state = adv_end ? ST_CP_RD : ST_SC_RD;
                end
            end
            ST_SC_RGT: begin
                if (r_pix_q) begin
                    n_state = ST_FA_CHK;
                end else if (!last_y) begin
                    n_state = ST_SC_DWN;
                end else begin
                    n_state = adv_end ? ST_CP_RD : ST_SC_RD;
                end
            end
            ST_SC_DWN: begin
                if (r_pix_q) begin
                    n_state = ST_FA_CHK;
                end else begin
                    n_state = adv_end ? ST_CP_RD : ST_SC_RD;
                end
            end
            ST_FA_CHK: n_state = (lab_par == r_cur) ? ST_FB_CHK : ST_FA_CHK;
            ST_FB_CHK: begin
                if (lab_par != r_cur) begin
                    n_state = ST_FB_CHK;
                end else if (!r_dir && !last_y) begin
                    n_state = ST_SC_DWN;
                end else begin
                    n_state = adv_end ? ST_CP_RD : ST_SC_RD;
                end
            end
            ST_CP_RD:  n_state = ST_CP_CUR;
            ST_CP_CUR: begin
                if (r_pix_q) begin
                    n_state = ST_CP_CHK;
                end else begin
                    n_state = adv_end ? ST_GR_RD : ST_CP_RD;
                end
            end
            ST_CP_CHK: begin
                if (lab_par != r_cur) begin
                    n_state = ST_CP_CHK;
                end else begin
                    n_state = adv_end ? ST_GR_RD : ST_CP_RD;
                end
            end
            ST_GR_RD:  n_state = ST_GR_CUR;
            ST_GR_CUR: begin
                if (r_pix_q) begin
                    n_state = ST_GR_PAR;
                end else begin
                    n_state = adv_end ? ST_FIN : ST_GR_RD;
                end
            end
            ST_GR_PAR:  n_state = ST_GR_SEEN;
            ST_GR_SEEN: n_state = adv_end ? ST_FIN : ST_GR_RD;
            ST_FIN:     n_state = ST_DONE;
            ST_RD_PIX:  n_state = rd_ok ? ST_RD_PAR : ST_DONE;
            ST_RD_PAR:  n_state = ST_RD_GRP;
            ST_RD_GRP:  n_state = ST_DONE;
            ST_DONE:    n_state = i_ctl.take ? ST_IDLE : ST_DONE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_x      = r_x;
        n_y      = r_y;
        n_lin    = r_lin;
        n_addr   = r_addr;
        n_cur    = r_cur;
        n_ra     = r_ra;
        n_jb     = r_jb;
        n_dir    = r_dir;
        n_n      = r_n;
        n_count  = r_count;
        n_groups = r_groups;
        n_valid  = r_valid;
        n_rx     = r_rx;
        n_ry     = r_ry;
        n_res    = r_res;
        pix_we   = 1'b0;
        pix_wa   = in_addr;
        pix_wd   = i_word.pixel_on;
        pix_ra   = r_addr;
        lab_we   = 1'b0;
        lab_wa   = r_cur;
        lab_wd   = {1'b0, IDX_W'(0), r_ra};
        lab_ra   = r_cur;
        if (i_ctl.cfg_wr) begin
            n_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                pix_ra = in_addr;
                n_rx   = i_word.col_x;
                n_ry   = i_word.row_y;
                n_x    = '0;
                n_y    = '0;
                n_lin  = '0;
                n_addr = '0;
                n_n    = (IDX_W + 1)'(i_w * i_h);
                if (i_ctl.start && cmd == CMD_LOAD) begin
                    pix_we  = in_store;
                    n_valid = 1'b0;
                end
                n_count = '0;
            end
            ST_INIT: begin
                lab_we = 1'b1;
                lab_wa = r_lin;
                lab_wd = {1'b0, IDX_W'(0), r_lin};
                n_lin  = (r_lin == IDX_W'(r_n - 1'b1)) ? '0 : r_lin + IDX_W'(1);
            end
            ST_SC_CUR: begin
                if (r_pix_q && !last_x) begin
                    pix_ra = r_addr + IDX_W'(1);
                end else if (r_pix_q && !last_y) begin
                    pix_ra = r_addr + IDX_W'(MAX_WIDTH);
                end else begin
                    n_x = adv_x; n_y = adv_y; n_lin = adv_lin; n_addr = adv_addr;
                end
            end
            ST_SC_RGT: begin
                if (r_pix_q) begin
                    lab_ra = r_lin;
                    n_cur  = r_lin;
                    n_jb   = r_lin + IDX_W'(1);
                    n_dir  = 1'b0;
                end else if (!last_y) begin
                    pix_ra = r_addr + IDX_W'(MAX_WIDTH);
                end else begin
                    n_x = adv_x; n_y = adv_y; n_lin = adv_lin; n_addr = adv_addr;
                end
            end
            ST_SC_DWN: begin
                if (r_pix_q) begin
                    lab_ra = r_lin;
                    n_cur  = r_lin;
                    n_jb   = r_lin + IDX_W'(i_w);
                    n_dir  = 1'b1;
                end else begin
                    n_x = adv_x; n_y = adv_y; n_lin = adv_lin; n_addr = adv_addr;
                end
            end
            ST_FA_CHK: begin
                if (lab_par == r_cur) begin
                    n_ra   = r_cur;
                    n_cur  = r_jb;
                    lab_ra = r_jb;
                end else begin
                    n_cur  = lab_par;
                    lab_ra = lab_par;
                end
            end
            ST_FB_CHK: begin
                if (lab_par != r_cur) begin
                    n_cur  = lab_par;
                    lab_ra = lab_par;
                end else begin
                    // Second root now points at the first.
                    lab_we = 1'b1;
                    if (!r_dir && !last_y) begin
                        pix_ra = r_addr + IDX_W'(MAX_WIDTH);
                    end else begin
                        n_x = adv_x; n_y = adv_y; n_lin = adv_lin; n_addr = adv_addr;
                    end
                end
            end
            ST_CP_CUR: begin
                if (r_pix_q) begin
                    n_cur  = r_lin;
                    lab_ra = r_lin;
                end else begin
                    n_x = adv_x; n_y = adv_y; n_lin = adv_lin; n_addr = adv_addr;
                end
            end
            ST_CP_CHK: begin
                if (lab_par != r_cur) begin
                    n_cur  = lab_par;
                    lab_ra = lab_par;
                end else begin
                    lab_we = 1'b1;
                    lab_wa = r_lin;
                    lab_wd = {1'b0, IDX_W'(0), r_cur};
                    n_x = adv_x; n_y = adv_y; n_lin = adv_lin; n_addr = adv_addr;
                end
            end
            ST_GR_CUR: begin
                lab_ra = r_lin;
                if (!r_pix_q) begin
                    n_x = adv_x; n_y = adv_y; n_lin = adv_lin; n_addr = adv_addr;
                end
            end
            ST_GR_PAR: begin
                n_cur  = lab_par;
                lab_ra = lab_par;
            end
            ST_GR_SEEN: begin
                if (!lab_seen) begin
                    lab_we  = 1'b1;
                    lab_wd  = {1'b1, IDX_W'(r_count), r_cur};
                    n_count = r_count + (IDX_W + 1)'(1);
                end
                n_x = adv_x; n_y = adv_y; n_lin = adv_lin; n_addr = adv_addr;
            end
            ST_FIN: begin
                n_groups = r_count;
                n_valid  = 1'b1;
                n_res    = '{foreground: 1'b0, root_index: '0, group_number: '0,
                             group_count: 15'(r_count)};
            end
            ST_RD_PIX: begin
                lab_ra = rd_lin;
                n_res  = '{foreground: 1'b0, root_index: '0, group_number: '0,
                           group_count: 15'(r_groups)};
            end
            ST_RD_PAR: begin
                n_cur  = lab_par;
                lab_ra = lab_par;
            end
            ST_RD_GRP: begin
                n_res = '{foreground: 1'b1, root_index: 14'(r_cur),
                          group_number: 14'(lab_grp), group_count: 15'(r_groups)};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= 1'b0;
            r_groups <= '0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_groups <= n_groups;
        end
        r_x     <= n_x;
        r_y     <= n_y;
        r_lin   <= n_lin;
        r_addr  <= n_addr;
        r_cur   <= n_cur;
        r_ra    <= n_ra;
        r_jb    <= n_jb;
        r_dir   <= n_dir;
        r_n     <= n_n;
        r_count <= n_count;
        r_rx    <= n_rx;
        r_ry    <= n_ry;
        r_res   <= n_res;
    end

    assign o_sts = '{busy: (r_state != ST_IDLE), res_valid: (r_state == ST_DONE)};
    assign o_res = r_res;

endmodule

FILE: rtl/core/binary_map_component_labeler_top.sv
`timescale 1ns / 1ps
// Labels the 4-connected regions of a binary map held on chip. A load word
// writes one pixel; it gives no result. A read word gives a background result
// from the pixel read alone when the pixel lies outside the active area, is
// clear or the labels are stale, and otherwise after two dependent label
// memory reads that follow the pixel read. A run word walks the active area
// w*h four times: to initialise parents; to scan, joining each set pixel with
// its set right and lower neighbours by finding both roots and pointing the
// second root at the first; to flatten, setting each set pixel's parent to its
// root; and to number the groups, before it posts the result. Every step waits
// on the registered read of the pixel and label memories. No word is taken
// while a run or read is in progress or while its result waits for the output
// register; in between, loads are taken every cycle.
module binary_map_component_labeler_top
    import bmcl_pkg::*;
#(
    parameter int MAX_WIDTH  = BMCL_MAX_WIDTH,
    parameter int MAX_HEIGHT = BMCL_MAX_HEIGHT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word,
    input  logic      i_cfg_we,
    input  logic      i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int DW_W = $clog2(MAX_WIDTH + 1);
    localparam int DH_W = $clog2(MAX_HEIGHT + 1);

    logic [7:0]      r_cfg_w, r_cfg_h;
    logic [DW_W-1:0] eff_w;
    logic [DH_W-1:0] eff_h;
    logic            r_out_valid;
    t_out_word       r_out;
    t_core_ctl       ctl;
    t_core_sts       sts;
    t_out_word       res;

    // The size registers saturate into the range the storage supports.
    always_comb begin
        if (r_cfg_w == 8'd0) begin
            eff_w = DW_W'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            eff_w = DW_W'(MAX_WIDTH);
        end else begin
            eff_w = DW_W'(r_cfg_w);
        end
        if (r_cfg_h == 8'd0) begin
            eff_h = DH_W'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            eff_h = DH_W'(MAX_HEIGHT);
        end else begin
            eff_h = DH_W'(r_cfg_h);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= 8'd128;
            r_cfg_h <= 8'd128;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_MAP_WIDTH) begin
                r_cfg_w <= i_cfg_data;
            end
            if (i_cfg_index == CFG_MAP_HEIGHT) begin
                r_cfg_h <= i_cfg_data;
            end
        end
    end

    assign ctl = '{start:  i_in_valid && !sts.busy,
                   cfg_wr: i_cfg_we,
                   take:   sts.res_valid && (!r_out_valid || !i_out_stall)};

    bmcl_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_word  (i_in_word),
        .i_w     (eff_w),
        .i_h     (eff_h),
        .o_sts   (sts),
        .o_res   (res)
    );

    // Output register: holds a finished word until the far side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (ctl.take) begin
            r_out <= res;
        end
    end

    assign o_in_stall  = sts.busy;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

FILE: sim/tb_binary_map_component_labeler_top.sv
`timescale 1ns / 1ps
module tb_binary_map_component_labeler_top;
    import bmcl_pkg::*;

    localparam int          CELLS       = BMCL_MAX_WIDTH * BMCL_MAX_HEIGHT;
    // The one command code that the package leaves unnamed; the block ignores it.
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam int          DRAIN_WAIT  = 40;
    localparam int          HOLD_CYCLES = 4000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_word   i_in_word = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_word  o_out_word;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_index = CFG_MAP_WIDTH;
    logic [7:0] i_cfg_data = '0;

    binary_map_component_labeler_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Our own copy of the map and the label state, kept in step with the
    // words that the block accepts.
    bit         map_pix [CELLS];
    int         map_parent [CELLS];
    int         map_group [CELLS];
    bit         map_seen [CELLS];
    bit         labels_ok;
    int         groups_seen;
    logic [7:0] width_reg;
    logic [7:0] height_reg;

    t_in_word   pending_words[$];
    t_out_word  expected_labels[$];
    int         mismatch_count = 0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    int         hold_requests = 0;
    int         holds_served = 0;
    int         hold_left = 0;

    function automatic void add_word(t_in_word wd);
        pending_words.insert(pending_words.size(), wd);
    endfunction

    function automatic void add_expected(t_out_word res);
        expected_labels.insert(expected_labels.size(), res);
    endfunction

    function automatic int active_w();
        if (width_reg < 1) return 1;
        if (width_reg > BMCL_MAX_WIDTH) return BMCL_MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int active_h();
        if (height_reg < 1) return 1;
        if (height_reg > BMCL_MAX_HEIGHT) return BMCL_MAX_HEIGHT;
        return height_reg;
    endfunction

    // Storage address of a linear index in the active area.
    function automatic int store_addr(int idx, int w);
        int a;
        a = (idx / w) * BMCL_MAX_WIDTH + (idx % w);
        return (a < CELLS) ? a : 0;
    endfunction

    // Follows parent links until a self-pointing entry; no compression.
    function automatic int root_of(int idx, int w, int h);
        int lim;
        int steps;
        int p;
        lim = w * h;
        steps = 0;
        while (steps <= lim) begin
            p = map_parent[store_addr(idx, w)];
            if (p == idx || p >= lim) break;
            idx = p;
            steps++;
        end
        return idx;
    endfunction

    function automatic void merge_sets(int first, int second, int w, int h);
        int ra;
        int rb;
        ra = root_of(first, w, h);
        rb = root_of(second, w, h);
        map_parent[store_addr(rb, w)] = ra;
    endfunction

    function automatic void label_regions();
        int w;
        int h;
        int r;
        int count;
        w = active_w();
        h = active_h();
        count = 0;
        for (int x = 0; x < w; x++)
            for (int y = 0; y < h; y++)
                map_parent[y * BMCL_MAX_WIDTH + x] = y * w + x;
        // Column-major scan: join with the right neighbour, then the lower one.
        for (int x = 0; x < w; x++) begin
            for (int y = 0; y < h; y++) begin
                if (map_pix[y * BMCL_MAX_WIDTH + x]) begin
                    if (x + 1 < w && map_pix[y * BMCL_MAX_WIDTH + x + 1])
                        merge_sets(y * w + x, y * w + x + 1, w, h);
                    if (y + 1 < h && map_pix[(y + 1) * BMCL_MAX_WIDTH + x])
                        merge_sets(y * w + x, (y + 1) * w + x, w, h);
                end
            end
        end
        for (int x = 0; x < w; x++)
            for (int y = 0; y < h; y++)
                if (map_pix[y * BMCL_MAX_WIDTH + x])
                    map_parent[y * BMCL_MAX_WIDTH + x] = root_of(y * w + x, w, h);
        for (int i = 0; i < CELLS; i++) map_seen[i] = 1'b0;
        for (int x = 0; x < w; x++) begin
            for (int y = 0; y < h; y++) begin
                if (map_pix[y * BMCL_MAX_WIDTH + x]) begin
                    r = map_parent[y * BMCL_MAX_WIDTH + x];
                    if (r < CELLS && !map_seen[r]) begin
                        map_seen[r] = 1'b1;
                        map_group[r] = count;
                        count++;
                    end
                end
            end
        end
        groups_seen = count;
        labels_ok = 1'b1;
    endfunction

    // Applies one accepted word and queues the result that it should give.
    function automatic void label_map_step(t_in_word wd);
        t_out_word res;
        int        r;
        int        a;
        res = '0;
        a = wd.row_y * BMCL_MAX_WIDTH + wd.col_x;
        case (wd.command)
            CMD_LOAD: begin
                map_pix[a] = wd.pixel_on;
                labels_ok = 1'b0;
                return;
            end
            CMD_RUN: label_regions();
            CMD_READ: begin
                if (labels_ok && wd.col_x < active_w() && wd.row_y < active_h()
                        && map_pix[a]) begin
                    r = map_parent[a];
                    res.foreground = 1'b1;
                    res.root_index = r[13:0];
                    res.group_number = (r < CELLS) ? map_group[r][13:0] : '0;
                end
            end
            default: return;
        endcase
        res.group_count = groups_seen[14:0];
        add_expected(res);
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        $display("mismatch in %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
        mismatch_count++;
    endtask

    // Driver: the payload only changes once the current word has been taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) label_map_step(i_in_word);
            if (!i_in_valid || !o_in_stall) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_word <= pending_words.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall, with an occasional long hold-off so that the block backs up.
    always @(posedge i_clk) begin
        if (hold_requests != holds_served) begin
            holds_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Monitor: every result word is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_labels.size() == 0) begin
                report_mismatch("unexpected result words", 0, 1);
            end else begin
                want = expected_labels.pop_front();
                if (o_out_word.foreground !== want.foreground)
                    report_mismatch("foreground", want.foreground, o_out_word.foreground);
                if (o_out_word.root_index !== want.root_index)
                    report_mismatch("root_index", want.root_index, o_out_word.root_index);
                if (o_out_word.group_number !== want.group_number)
                    report_mismatch("group_number", want.group_number,
                                    o_out_word.group_number);
                if (o_out_word.group_count !== want.group_count)
                    report_mismatch("group_count", want.group_count, o_out_word.group_count);
            end
        end
    end

    function automatic t_in_word make_word(logic [1:0] cmd, int x, int y, bit on);
        t_in_word wd;
        wd.command = cmd;
        wd.col_x = x[6:0];
        wd.row_y = y[6:0];
        wd.pixel_on = on;
        return wd;
    endfunction

    task automatic write_reg(logic idx, logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        if (idx == CFG_MAP_WIDTH) width_reg = value;
        else height_reg = value;
        labels_ok = 1'b0;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every queued word is taken and every result has come back,
    // then lets a load still in flight settle.
    task automatic drain();
        while (pending_words.size() != 0 || i_in_valid || expected_labels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // One phase: new map size, a full load of the active area (so that no run
    // ever sees an unwritten pixel), the directed words if asked, then random traffic.
    task automatic run_phase(logic [7:0] wv, logic [7:0] hv, int n_words, int idle,
                             int stall, bit hold, bit directed);
        int w;
        int h;
        int density;
        int pick;
        write_reg(CFG_MAP_WIDTH, wv);
        write_reg(CFG_MAP_HEIGHT, hv);
        send_idle_pct = idle;
        stall_pct = stall;
        w = active_w();
        h = active_h();
        density = $urandom_range(30, 75);
        for (int x = 0; x < w; x++)
            for (int y = 0; y < h; y++)
                add_word(make_word(CMD_LOAD, x, y, $urandom_range(99) < density));
        if (directed) begin
            // Read before any run: labels not yet valid.
            add_word(make_word(CMD_READ, 0, 0, 1'b0));
            add_word(make_word(CMD_RUN, 0, 0, 1'b0));
            add_word(make_word(CMD_READ, 0, 0, 1'b0));
            add_word(make_word(CMD_READ, w - 1, h - 1, 1'b1));
            add_word(make_word(CMD_READ, w - 1, 0, 1'b0));
            add_word(make_word(CMD_READ, 0, h - 1, 1'b0));
            // Reads outside the active area, including the storage corner.
            add_word(make_word(CMD_READ, 127, 127, 1'b0));
            add_word(make_word(CMD_READ, w, 0, 1'b0));
            // Unknown command, ignored.
            add_word(make_word(CMD_UNUSED, 127, 127, 1'b1));
            // A load outside the active area is stored and still drops the labels.
            add_word(make_word(CMD_LOAD, 127, 127, 1'b1));
            add_word(make_word(CMD_READ, 0, 0, 1'b0));
            add_word(make_word(CMD_LOAD, 0, 0, 1'b1));
            add_word(make_word(CMD_LOAD, w - 1, h - 1, 1'b0));
            add_word(make_word(CMD_RUN, 127, 127, 1'b1));
            add_word(make_word(CMD_READ, 0, 0, 1'b1));
            add_word(make_word(CMD_READ, w - 1, h - 1, 1'b0));
        end
        if (hold) hold_requests++;
        for (int i = 0; i < n_words; i++) begin
            pick = $urandom_range(99);
            if (pick < 50)
                add_word(make_word(CMD_LOAD, $urandom_range(w - 1),
                                   $urandom_range(h - 1), $urandom_range(99) < density));
            else if (pick < 55)
                add_word(make_word(CMD_LOAD, $urandom_range(127),
                                   $urandom_range(127), $urandom_range(1)));
            else if (pick < 65)
                add_word(make_word(CMD_RUN, $urandom_range(127),
                                   $urandom_range(127), $urandom_range(1)));
            else if (pick < 92)
                add_word(make_word(CMD_READ, $urandom_range(w - 1),
                                   $urandom_range(h - 1), $urandom_range(1)));
            else if (pick < 97)
                add_word(make_word(CMD_READ, $urandom_range(127),
                                   $urandom_range(127), $urandom_range(1)));
            else
                add_word(make_word(CMD_UNUSED, $urandom_range(127),
                                   $urandom_range(127), $urandom_range(1)));
        end
        drain();
    endtask

    initial begin
        for (int i = 0; i < CELLS; i++) begin
            map_pix[i] = 1'b0;
            map_parent[i] = 0;
            map_group[i] = 0;
            map_seen[i] = 1'b0;
        end
        labels_ok = 1'b0;
        groups_seen = 0;
        width_reg = 8'd128;
        height_reg = 8'd128;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_phase(8'd8,   8'd8,   50,  0,  0, 1'b0, 1'b1);
        run_phase(8'd128, 8'd1,   50, 75,  0, 1'b0, 1'b0);
        run_phase(8'd1,   8'd128, 50,  0, 75, 1'b0, 1'b0);
        // Zero saturates up to one, and an oversized value down to the maximum.
        run_phase(8'd0,   8'd0,   25, 27, 27, 1'b0, 1'b1);
        run_phase(8'd255, 8'd2,   50,  0,  0, 1'b1, 1'b0);
        run_phase(8'd2,   8'd255, 50, 75,  0, 1'b0, 1'b0);
        run_phase(8'd12,  8'd10,  50,  0, 75, 1'b0, 1'b0);
        run_phase(8'd16,  8'd16,  50, 27, 27, 1'b0, 1'b1);
        run_phase(8'd5,   8'd3,   50,  0,  0, 1'b0, 1'b0);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: binary_map_component_labeler_top.f
rtl/core/bmcl_pkg.sv
rtl/core/bmcl_core.sv
rtl/core/binary_map_component_labeler_top.sv
sim/tb_binary_map_component_labeler_top.sv
